// ----- rtl/rgb_colour_wheel_stepper_macros.svh -----
// Assertion macros for the RTL; only rgb_colour_wheel_stepper.sv includes them.
`ifndef RGB_COLOUR_WHEEL_STEPPER_MACROS_SVH
`define RGB_COLOUR_WHEEL_STEPPER_MACROS_SVH

`ifndef SYNTH
// Checked only outside reset; uses the clk and rst_n of the enclosing module.
`define RGBCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RGBCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGBCW_ASSERT(lbl, prop, msg)
`define RGBCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/rgbcw_pkg.sv -----
package rgbcw_pkg;

  typedef logic [7:0] level_t;
  typedef logic [2:0] phase_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    phase_t phase;
  } colour_t;

  localparam level_t CH_MAX = 8'hFF;
  localparam level_t CH_MIN = 8'h00;
  localparam logic [9:0] SUM_ONE = 10'd255;
  localparam logic [9:0] SUM_PAIR = 10'd510;

  localparam phase_t PH_R2G = 3'd0;
  localparam phase_t PH_G2B = 3'd1;
  localparam phase_t PH_B2R = 3'd2;
  localparam phase_t PH_R2Y = 3'd3;
  localparam phase_t PH_Y2C = 3'd4;
  localparam phase_t PH_C2M = 3'd5;
  localparam phase_t PH_M2R = 3'd6;

  localparam colour_t COLOUR_RESET = '{red: CH_MAX, green: CH_MIN, blue: CH_MIN, phase: PH_R2G};

endpackage

// ----- rtl/rgbcw_step.sv -----
module rgbcw_step
  import rgbcw_pkg::*;
(
  input  colour_t cur,
  input  level_t  step_size,
  output colour_t nxt
);

  function automatic colour_t col(input level_t r, input level_t g, input level_t b,
                                  input phase_t ph);
    colour_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    c.phase = ph;
    return c;
  endfunction

  logic [9:0] sum;
  logic       snap;
  colour_t    snap_col;
  colour_t    base;
  level_t     mov;
  logic [8:0] up;
  logic       up_done;
  level_t     upl;
  logic       dn_done;
  level_t     dn;

  always_comb begin
    sum      = {2'b00, cur.red} + {2'b00, cur.green} + {2'b00, cur.blue};
    snap     = 1'b0;
    snap_col = cur;
    case (cur.phase)
      PH_R2G: begin
        snap     = (sum != SUM_ONE);
        snap_col = col(CH_MAX, CH_MIN, CH_MIN, PH_R2G);
      end
      PH_G2B: begin
        snap     = (sum != SUM_ONE);
        snap_col = col(CH_MIN, CH_MAX, CH_MIN, PH_G2B);
      end
      PH_B2R: begin
        snap     = (sum != SUM_ONE);
        snap_col = col(CH_MIN, CH_MIN, CH_MAX, PH_B2R);
      end
      PH_R2Y: begin
        snap     = (cur.red != CH_MAX) && (cur.blue == CH_MIN);
        snap_col = col(CH_MAX, CH_MIN, CH_MIN, PH_R2Y);
      end
      PH_Y2C: begin
        snap     = (sum != SUM_PAIR);
        snap_col = col(CH_MAX, CH_MAX, CH_MIN, PH_Y2C);
      end
      PH_C2M: begin
        snap     = (sum != SUM_PAIR);
        snap_col = col(CH_MIN, CH_MAX, CH_MAX, PH_C2M);
      end
      PH_M2R: begin
        snap     = (cur.red != CH_MAX) && (cur.green == CH_MIN);
        snap_col = col(CH_MAX, CH_MIN, CH_MAX, PH_M2R);
      end
      default: begin
        snap     = 1'b0;
        snap_col = cur;
      end
    endcase
    base = snap ? snap_col : cur;

    case (cur.phase)
      PH_R2G, PH_R2Y:         mov = base.green;
      PH_G2B, PH_Y2C, PH_M2R: mov = base.blue;
      PH_B2R, PH_C2M:         mov = base.red;
      default:                mov = CH_MIN;
    endcase

    up      = {1'b0, mov} + {1'b0, step_size};
    up_done = (up >= {1'b0, CH_MAX});
    upl     = up[7:0];
    dn_done = (mov <= step_size);
    dn      = mov - step_size;

    case (cur.phase)
      PH_R2G: nxt = up_done ? col(CH_MIN, CH_MAX, CH_MIN, PH_G2B)
                            : col(CH_MAX - upl, upl, base.blue, PH_R2G);
      PH_G2B: nxt = up_done ? col(CH_MIN, CH_MIN, CH_MAX, PH_B2R)
                            : col(base.red, CH_MAX - upl, upl, PH_G2B);
      PH_B2R: nxt = up_done ? col(CH_MAX, CH_MIN, CH_MIN, PH_R2Y)
                            : col(upl, base.green, CH_MAX - upl, PH_B2R);
      PH_R2Y: nxt = up_done ? col(CH_MAX, CH_MAX, CH_MIN, PH_Y2C)
                            : col(CH_MAX, upl, CH_MIN, PH_R2Y);
      PH_Y2C: nxt = up_done ? col(CH_MIN, CH_MAX, CH_MAX, PH_C2M)
                            : col(CH_MAX - upl, base.green, upl, PH_Y2C);
      PH_C2M: nxt = up_done ? col(CH_MAX, CH_MIN, CH_MAX, PH_M2R)
                            : col(upl, CH_MAX - upl, base.blue, PH_C2M);
      PH_M2R: nxt = dn_done ? col(CH_MAX, CH_MIN, CH_MIN, PH_R2G)
                            : col(base.red, base.green, dn, PH_M2R);
      default: nxt = cur;
    endcase
  end

endmodule

// ----- rtl/rgb_colour_wheel_stepper.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_hold in_load in_load_red/green/blue
// out       output     out_valid/out_ready  out_red_out out_green_out out_blue_out
//                                           out_phase_out
// cfg       input      cfg_valid/cfg_ready  cfg_step_size
//
// The colour register is updated at the accepting edge
// and is the result register, valid in the next cycle.
// The step logic is combinational between the registers: a 9-bit add, an 8-bit subtract, compares and a select.
// A new request is taken every cycle while out_ready is high; a stalled result blocks input.
// Synchronous reset gives red 255, green 0, blue 0, phase 0 and step size 1.
`include "rgb_colour_wheel_stepper_macros.svh"

module rgb_colour_wheel_stepper
  import rgbcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_hold,
  input  logic       in_load,
  input  logic [7:0] in_load_red,
  input  logic [7:0] in_load_green,
  input  logic [7:0] in_load_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [2:0] out_phase_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_step_size
);

  colour_t colour_r;
  colour_t colour_nxt;
  colour_t step_col;
  colour_t load_col;
  level_t  step_size_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_acc;

  rgbcw_step u_step (
    .cur       (colour_r),
    .step_size (step_size_r),
    .nxt       (step_col)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    load_col.red   = in_load_red;
    load_col.green = in_load_green;
    load_col.blue  = in_load_blue;
    load_col.phase = colour_r.phase;
    colour_nxt     = colour_r;
    if (in_acc && !in_hold) begin
      colour_nxt = in_load ? load_col : step_col;
    end
    out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r    <= COLOUR_RESET;
      step_size_r <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      colour_r    <= colour_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        step_size_r <= cfg_step_size;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = colour_r.red;
  assign out_green_out = colour_r.green;
  assign out_blue_out  = colour_r.blue;
  assign out_phase_out = colour_r.phase;

  `RGBCW_ASSERT(a_hold_keeps, (in_acc && in_hold) |=> $stable(colour_r), "hold changed colour")
  `RGBCW_ASSERT(a_step_phase, (in_acc && !in_hold && !in_load) |=> ((colour_r.phase == $past(colour_r.phase)) || (colour_r.phase == $past(colour_r.phase) + 3'd1) || (($past(colour_r.phase) == PH_M2R) && (colour_r.phase == PH_R2G))), "phase skipped")
  `RGBCW_ASSERT(a_load_takes, (in_acc && !in_hold && in_load) |=> ((colour_r.red == $past(in_load_red)) && (colour_r.blue == $past(in_load_blue)) && $stable(colour_r.phase)), "load not applied")
  `RGBCW_ASSERT(a_result_up, in_acc |=> out_valid_r, "accepted request gave no result")
  `RGBCW_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
